### rtl/core/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types, constants and helpers for the four-bone skinning block.
// ----------------------------------------------------------------------------
package lbvs_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
	localparam int FIELD_BONES   = 4;
	localparam int BONE_CNT_W    = 3;
	localparam int BONE_SEL_W    = 2;
	localparam int ROWS          = 4;
	localparam int COLS          = 3;
	localparam int ACC_W         = 51;
	localparam int TW_W          = 48;
	localparam logic [7:0] END_INDEX = 8'd255;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SKIN  = 1'b1;

	typedef logic [2:0][31:0] vec3_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// palette write toward one lane (one matrix column)
	typedef struct packed {
		logic              en;
		logic [1:0]        row;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} pal_wr_t;

	// per-cycle control shared by all lanes
	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic [15:0]       weight;
		logic              acc_en;
		logic              acc_clr;
	} lane_ctl_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] row;
		logic [1:0] col;
	} word_loc_t;

	// word_select -> (row, column)
	function automatic word_loc_t decode_word(input logic [3:0] ws);
		word_loc_t loc;
		loc = '{ok: 1'b1, row: 2'd0, col: 2'd0};
		unique case (ws)
			4'd0:    begin loc.row = 2'd0; loc.col = 2'd0; end
			4'd1:    begin loc.row = 2'd0; loc.col = 2'd1; end
			4'd2:    begin loc.row = 2'd0; loc.col = 2'd2; end
			4'd3:    begin loc.row = 2'd1; loc.col = 2'd0; end
			4'd4:    begin loc.row = 2'd1; loc.col = 2'd1; end
			4'd5:    begin loc.row = 2'd1; loc.col = 2'd2; end
			4'd6:    begin loc.row = 2'd2; loc.col = 2'd0; end
			4'd7:    begin loc.row = 2'd2; loc.col = 2'd1; end
			4'd8:    begin loc.row = 2'd2; loc.col = 2'd2; end
			4'd9:    begin loc.row = 2'd3; loc.col = 2'd0; end
			4'd10:   begin loc.row = 2'd3; loc.col = 2'd1; end
			4'd11:   begin loc.row = 2'd3; loc.col = 2'd2; end
			default: loc.ok = 1'b0;
		endcase
		return loc;
	endfunction

	// influences before the first end marker
	function automatic logic [BONE_CNT_W-1:0] count_bones(input logic [31:0] idx);
		logic [BONE_CNT_W-1:0] n;
		logic                  stop;
		n    = '0;
		stop = 1'b0;
		for (int b = 0; b < FIELD_BONES; b++) begin
			if (idx[8*b +: 8] == END_INDEX)
				stop = 1'b1;
			if (!stop)
				n = n + 1'b1;
		end
		return n;
	endfunction

endpackage

### rtl/core/lbvs_lane.sv
// ----------------------------------------------------------------------------
// lbvs_lane
// One output coordinate: column memories, 3-term dot product, weight, sum.
// ----------------------------------------------------------------------------
module lbvs_lane (
	input  logic                clk,
	input  lbvs_pkg::pal_wr_t   wr,
	input  lbvs_pkg::lane_ctl_t ctl,
	input  lbvs_pkg::vec3_t     pos,
	output logic [31:0]         result
);

	logic [31:0] bank0 [lbvs_pkg::PALETTE_DEPTH];
	logic [31:0] bank1 [lbvs_pkg::PALETTE_DEPTH];
	logic [31:0] bank2 [lbvs_pkg::PALETTE_DEPTH];
	logic [31:0] bank3 [lbvs_pkg::PALETTE_DEPTH];

	logic [3:0][31:0]         m_s1;
	logic [15:0]              w_s1, w_s2, w_s3;
	logic signed [63:0]       p0_s2, p1_s2, p2_s2;
	logic [31:0]              m3_s2;
	logic signed [31:0]       t_s3;
	logic signed [lbvs_pkg::TW_W-1:0]  tw_s4;
	logic signed [lbvs_pkg::ACC_W-1:0] acc_q;

	logic signed [65:0] dot;
	logic signed [50:0] tsum;
	logic signed [lbvs_pkg::ACC_W-16:0] acc_sh;

	// one write port per bank, row picks the bank
	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.row)
				2'd0:    bank0[wr.addr] <= wr.data;
				2'd1:    bank1[wr.addr] <= wr.data;
				2'd2:    bank2[wr.addr] <= wr.data;
				default: bank3[wr.addr] <= wr.data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		m_s1[0] <= bank0[ctl.rd_addr];
		m_s1[1] <= bank1[ctl.rd_addr];
		m_s1[2] <= bank2[ctl.rd_addr];
		m_s1[3] <= bank3[ctl.rd_addr];
		w_s1    <= ctl.weight;
	end

	always_ff @(posedge clk) begin
		p0_s2 <= $signed(pos[0]) * $signed(m_s1[0]);
		p1_s2 <= $signed(pos[1]) * $signed(m_s1[1]);
		p2_s2 <= $signed(pos[2]) * $signed(m_s1[2]);
		m3_s2 <= m_s1[3];
		w_s2  <= w_s1;
	end

	// exact sum, floor by 2^16, add translation, clamp to Q16.16
	always_comb begin
		dot  = 66'(p0_s2) + 66'(p1_s2) + 66'(p2_s2);
		tsum = 51'(dot >>> 16) + 51'($signed(m3_s2));
	end

	always_ff @(posedge clk) begin
		if (tsum > 51'sd2147483647)
			t_s3 <= 32'sh7fffffff;
		else if (tsum < -51'sd2147483648)
			t_s3 <= 32'sh80000000;
		else
			t_s3 <= tsum[31:0];
		w_s3 <= w_s2;
	end

	always_ff @(posedge clk) begin
		tw_s4 <= t_s3 * $signed({1'b0, w_s3});
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_clr)
			acc_q <= '0;
		else if (ctl.acc_en)
			acc_q <= acc_q + lbvs_pkg::ACC_W'(tw_s4);
	end

	// floor by 2^15: the upper bits of the accumulator
	assign acc_sh = acc_q[lbvs_pkg::ACC_W-1:15];

	always_comb begin
		if (acc_sh > 36'sd2147483647)
			result = 32'h7fffffff;
		else if (acc_sh < -36'sd2147483648)
			result = 32'h80000000;
		else
			result = acc_sh[31:0];
	end

endmodule

### rtl/core/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Four-bone linear blend skinning over a 256-bone affine matrix palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries two transaction kinds. A palette
//   write (opcode 0) stores one Q16.16 matrix word. A skin transaction
//   (opcode 1) blends up to four bone influences into one output
//   transaction on out_valid/out_stall.
//   Three lanes, one per output coordinate, each hold one matrix column in
//   four 256-word banks (one per row), so a whole column reads at once.
//   One influence issues per cycle into a 4-stage lane pipeline (read,
//   multiply, sum/clamp, weight) feeding the lane accumulator.
//   Occupancy: a skin transaction holds in_stall high while its influences
//   issue, the influence pipeline drains and the result waits for the output
//   register; with no influences it goes straight to the done state.
//   palette_entries (cfg_wr_en/cfg_wr_data) of zero drops skin transactions.
//   Reset clears control state and palette_entries; palette contents are
//   undefined until written.
//   A stalled result sits in the output register; the next transaction is
//   taken meanwhile, but finishing it waits for the output register.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  entry_index,
	input  logic [3:0]  word_select,
	input  logic [31:0] word_value,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] bone_indices,
	input  logic [63:0] bone_weights,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [2:0]  influences_used
);

	lbvs_pkg::state_t state_q, state_d;

	logic [7:0]                          entries_q;
	lbvs_pkg::vec3_t                     pos_q;
	logic [31:0]                         idx_q;
	logic [63:0]                         wts_q;
	logic [lbvs_pkg::BONE_CNT_W-1:0]     n_q;
	logic [lbvs_pkg::BONE_SEL_W-1:0]     b_q;
	logic                                v_s1, v_s2, v_s3, v_s4;
	logic                                out_valid_q;

	logic                  in_take, skin_take, wr_take;
	logic                  issue, last_issue, pipe_busy, out_free, out_load;
	lbvs_pkg::word_loc_t   loc;
	lbvs_pkg::pal_wr_t     wr_x, wr_y, wr_z;
	lbvs_pkg::lane_ctl_t   ctl;
	logic [31:0]           res_x, res_y, res_z;
	logic [lbvs_pkg::BONE_CNT_W-1:0] n_in;

	assign in_take   = in_valid && !in_stall;
	assign skin_take = in_take && (opcode == lbvs_pkg::OP_SKIN) && (entries_q != 8'd0);
	assign wr_take   = in_take && (opcode == lbvs_pkg::OP_WRITE);
	assign n_in      = lbvs_pkg::count_bones(bone_indices);
	assign pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;
	assign out_free  = !out_valid_q || !out_stall;

	// ---- palette write decode: column picks the lane, row picks the bank
	always_comb begin
		loc = lbvs_pkg::decode_word(word_select);
		wr_x = '{en: 1'b0, row: loc.row, addr: entry_index[lbvs_pkg::ADDR_W-1:0],
			data: word_value};
		wr_y = wr_x;
		wr_z = wr_x;
		if (wr_take && loc.ok && (9'(entry_index) < 9'(lbvs_pkg::PALETTE_DEPTH))) begin
			wr_x.en = (loc.col == 2'd0);
			wr_y.en = (loc.col == 2'd1);
			wr_z.en = (loc.col == 2'd2);
		end
	end

	// ---- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbvs_pkg::ST_IDLE: begin
				if (skin_take)
					state_d = (n_in == '0) ? lbvs_pkg::ST_DONE : lbvs_pkg::ST_ISSUE;
			end
			lbvs_pkg::ST_ISSUE: begin
				if (last_issue)
					state_d = lbvs_pkg::ST_DRAIN;
			end
			lbvs_pkg::ST_DRAIN: begin
				if (!pipe_busy)
					state_d = lbvs_pkg::ST_DONE;
			end
			lbvs_pkg::ST_DONE: begin
				if (out_free)
					state_d = lbvs_pkg::ST_IDLE;
			end
			default: state_d = lbvs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		issue      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			lbvs_pkg::ST_IDLE:  in_stall = 1'b0;
			lbvs_pkg::ST_ISSUE: issue    = 1'b1;
			lbvs_pkg::ST_DRAIN: ;
			lbvs_pkg::ST_DONE:  out_load = out_free;
			default: ;
		endcase
		last_issue = issue && ({1'b0, b_q} == n_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbvs_pkg::ST_IDLE;
			entries_q   <= '0;
			b_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				entries_q <= cfg_wr_data;
			if (skin_take)
				b_q <= '0;
			else if (issue)
				b_q <= b_q + 1'b1;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// transaction payload held while the influences run
	always_ff @(posedge clk) begin
		if (skin_take) begin
			pos_q <= {pos_z, pos_y, pos_x};
			idx_q <= bone_indices;
			wts_q <= bone_weights;
			n_q   <= n_in;
		end
	end

	always_comb begin
		ctl.rd_addr = idx_q[8*b_q +: lbvs_pkg::ADDR_W];
		ctl.weight  = wts_q[16*b_q +: 16];
		ctl.acc_en  = v_s4;
		ctl.acc_clr = skin_take;
	end

	lbvs_lane u_lane_x (.clk(clk), .wr(wr_x), .ctl(ctl), .pos(pos_q), .result(res_x));
	lbvs_lane u_lane_y (.clk(clk), .wr(wr_y), .ctl(ctl), .pos(pos_q), .result(res_y));
	lbvs_lane u_lane_z (.clk(clk), .wr(wr_z), .ctl(ctl), .pos(pos_q), .result(res_z));

	// ---- merge: the three lane results form one output transaction
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x           <= res_x;
			out_y           <= res_y;
			out_z           <= res_z;
			influences_used <= n_q;
		end
	end

	assign out_valid = out_valid_q;

	// ---- checks
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lbvs_pkg::ST_DONE) |-> !pipe_busy)
		else $error("result taken while influences in flight");

	a_issue_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ($past(state_q) == lbvs_pkg::ST_ISSUE))
		else $error("influence issued outside issue phase");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == lbvs_pkg::ST_DONE))
		else $error("result without finished skin transaction");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (state_q == lbvs_pkg::ST_IDLE && !pipe_busy))
		else $error("input taken while busy");

endmodule
